### rtl/rmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter package
// Default sizes and shared constants for the running median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

  // Default number of samples held in the circular window.
  localparam int WINDOW_LEN_DEF = 7;

  // Default sample width in bits.
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Width of the reported fill count; wider counts are truncated to this.
  localparam int FILL_WIDTH = 3;

endpackage

### rtl/rmf_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter window
// Circular sample store with write position and fill tracking. Presents the
// window as it stands after the incoming sample is written.
// ----------------------------------------------------------------------------
module rmf_window #(
  parameter int WINDOW_LEN   = rmf_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF,
  localparam int CW = $clog2(WINDOW_LEN + 1),
  localparam int PW = $clog2(WINDOW_LEN)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   write_en,
  input  logic [SAMPLE_WIDTH-1:0]                sample,
  output logic [WINDOW_LEN-1:0][SAMPLE_WIDTH-1:0] win_view,
  output logic [CW-1:0]                          count_view
);

  logic [WINDOW_LEN-1:0][SAMPLE_WIDTH-1:0] window;
  logic [CW-1:0] write_position;
  logic [CW-1:0] write_position_next;
  logic          window_full;
  logic          window_full_next;
  logic          wrap;
  logic [CW-1:0] pos_eff;

  // A position that has reached the window length wraps before the write.
  assign wrap             = (write_position >= CW'(WINDOW_LEN));
  assign pos_eff          = wrap ? '0 : write_position;
  assign window_full_next = window_full | wrap;
  assign write_position_next = pos_eff + CW'(1);

  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win_view[i] = (pos_eff[PW-1:0] == PW'(i)) ? sample : window[i];
    end
    count_view = window_full_next ? CW'(WINDOW_LEN) : write_position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      window_full    <= 1'b0;
    end else if (write_en) begin
      write_position <= write_position_next;
      window_full    <= window_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      window[pos_eff[PW-1:0]] <= sample;
    end
  end

endmodule

### rtl/rmf_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter rank selector
// Picks the element of rank floor((n-1)/2) among the first n window entries.
// Equal samples rank by window position.
// ----------------------------------------------------------------------------
module rmf_rank #(
  parameter int WINDOW_LEN   = rmf_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF,
  localparam int CW = $clog2(WINDOW_LEN + 1)
) (
  input  logic [WINDOW_LEN-1:0][SAMPLE_WIDTH-1:0] win_view,
  input  logic [CW-1:0]                          count_view,
  output logic [SAMPLE_WIDTH-1:0]                median
);

  logic [CW-1:0] target;
  logic [WINDOW_LEN-1:0][CW-1:0] rank;

  assign target = (count_view - CW'(1)) >> 1;

  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (CW'(j) < count_view) begin
          if (($signed(win_view[j]) < $signed(win_view[i])) ||
              ((win_view[j] == win_view[i]) && (j < i))) begin
            rank[i] = rank[i] + CW'(1);
          end
        end
      end
    end
  end

  // Ranks among counted entries are distinct, so at most one entry matches.
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if ((CW'(i) < count_view) && (rank[i] == target)) begin
        median = median | win_view[i];
      end
    end
  end

endmodule

### rtl/running_median_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter core
// Median of the most recent samples held in a circular window.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel (in_valid/in_ready) carries one signed
// sample. The sample is written into a circular window, and one result request
// on the output channel (out_valid/out_ready) carries the median of the
// samples the window holds, together with fill_count, the number of samples
// the median was taken over. Until the window has filled once, only the
// samples written so far count; after that all WINDOW_LEN samples count.
// The result is registered: a sample's result shows in the output register
// from the cycle after its acceptance on. Throughput is one sample per cycle
// while the receiver takes results, set by the single pass of rank comparisons
// between the window and the output register. Reset empties the window (fill
// count back to zero) and drops any pending result. When the receiver stalls,
// the result holds in the output register and in_ready falls; it rises again
// in the same cycle the result is taken, so the stream keeps its full rate.
// ----------------------------------------------------------------------------
module running_median_filter_core #(
  parameter int WINDOW_LEN   = rmf_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_WIDTH = rmf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_WIDTH-1:0]        sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SAMPLE_WIDTH-1:0]        median,
  output logic [rmf_pkg::FILL_WIDTH-1:0] fill_count
);

  localparam int CW = $clog2(WINDOW_LEN + 1);

  logic                                   accept;
  logic [WINDOW_LEN-1:0][SAMPLE_WIDTH-1:0] win_view;
  logic [CW-1:0]                          count_view;
  logic [SAMPLE_WIDTH-1:0]                median_next;

  // The output register may be refilled in the cycle its content is taken.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rmf_window #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .write_en  (accept),
    .sample    (sample),
    .win_view  (win_view),
    .count_view(count_view)
  );

  rmf_rank #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_rank (
    .win_view  (win_view),
    .count_view(count_view),
    .median    (median_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; the fill count keeps only its low bits for wide windows.
  always_ff @(posedge clk) begin
    if (accept) begin
      median     <= median_next;
      fill_count <= rmf_pkg::FILL_WIDTH'(count_view);
    end
  end

endmodule
